FILE: hdl/eecce_pkg.sv
// Package for the EEPROM card command engine: codes, result type and a helper function.
package eecce_pkg;

    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_DEV_ACK    = 4'd1;
    localparam logic [3:0] PH_HI_FIRST   = 4'd2;
    localparam logic [3:0] PH_HI_RETRY   = 4'd3;
    localparam logic [3:0] PH_LO_FIRST   = 4'd4;
    localparam logic [3:0] PH_LO_RETRY   = 4'd5;
    localparam logic [3:0] PH_RD_DEV_ACK = 4'd6;
    localparam logic [3:0] PH_RD_DATA    = 4'd7;
    localparam logic [3:0] PH_WR_NEED    = 4'd8;
    localparam logic [3:0] PH_WR_ACK     = 4'd9;

    localparam logic [2:0] K_START = 3'd0;
    localparam logic [2:0] K_WRITE = 3'd1;
    localparam logic [2:0] K_READ  = 3'd2;
    localparam logic [2:0] K_STOP  = 3'd3;
    localparam logic [2:0] K_WAIT  = 3'd4;
    localparam logic [2:0] K_NEED  = 3'd5;
    localparam logic [2:0] K_REPLY = 3'd6;

    localparam logic [1:0] FN_HEADER = 2'd0;
    localparam logic [1:0] FN_DATA   = 2'd1;
    localparam logic [1:0] FN_BUS    = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_LEN  = 2'd1;
    localparam logic [1:0] ST_UNS  = 2'd2;
    localparam logic [1:0] ST_BUS  = 2'd3;

    localparam logic [1:0] REG_CARD_TYPE = 2'd0;
    localparam logic [1:0] REG_MAX_LEN   = 2'd1;
    localparam logic [1:0] REG_RETRY     = 2'd2;

    localparam logic [7:0] INS_READ  = 8'hB0;
    localparam logic [7:0] INS_WRITE = 8'hD0;
    localparam logic [7:0] DEV_BASE  = 8'hA0;

    localparam int RES_MAX   = 6;
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W     = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] bus_byte;
        logic       send_ack;
        logic [7:0] reply;
        logic       last;
        logic [1:0] status;
    } result_t;

    function automatic result_t mk(input logic [2:0] k, input logic [7:0] bb,
                                   input logic a, input logic [7:0] r,
                                   input logic l, input logic [1:0] s);
        result_t x;
        x.kind = k;
        x.bus_byte = bb;
        x.send_ack = a;
        x.reply = r;
        x.last = l;
        x.status = s;
        return x;
    endfunction

endpackage

FILE: hdl/eeprom_card_command_engine.sv
// EEPROM card command engine: one beat in, its bus operations and reply bytes out.
// Results of an input beat are registered into the result queue when the beat is accepted.
// Throughput: one input beat per cycle while the 8-entry result queue has room for six;
// results drain one per cycle, so the output port sets the sustained rate.
// Reset: asynchronous active-low; idle phase, empty queue, registers at their defaults.
module eeprom_card_command_engine
    import eecce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] func,
    input  logic [7:0] ins,
    input  logic [7:0] addr_high,
    input  logic [7:0] addr_low,
    input  logic [7:0] length,
    input  logic [7:0] data_byte,
    input  logic       bus_ack,
    input  logic [7:0] bus_read_value,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] kind,
    output logic [7:0] bus_byte,
    output logic       send_ack,
    output logic [7:0] reply,
    output logic       last,
    output logic [1:0] status
);

    logic [2:0] card_type_reg;
    logic [7:0] max_len_reg, retry_reg;
    logic [3:0] phase_reg, phase_next;
    logic       wr_reg, wr_next;
    logic [7:0] hi_reg, hi_next, lo_reg, lo_next, len_reg, len_next;
    logic [7:0] done_reg, done_next, att_reg, att_next, dev_reg, dev_next;

    result_t    fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   cnt_reg;

    result_t    res [RES_MAX];
    logic [2:0] nres;
    logic       fire, pop;

    assign in_ready  = (cnt_reg <= (PTR_W+1)'(FIFO_DEPTH - RES_MAX));
    assign fire      = in_valid && in_ready;
    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && out_ready;

    assign kind     = fifo_mem[rd_ptr_reg].kind;
    assign bus_byte = fifo_mem[rd_ptr_reg].bus_byte;
    assign send_ack = fifo_mem[rd_ptr_reg].send_ack;
    assign reply    = fifo_mem[rd_ptr_reg].reply;
    assign last     = fifo_mem[rd_ptr_reg].last;
    assign status   = fifo_mem[rd_ptr_reg].status;

    always_comb
    begin
        logic       big, do_try, do_fail, do_reply;
        logic [7:0] try_byte, rp0, rp1, top, pmask, d;
        logic [3:0] try_ph;
        logic [1:0] rst_st, chk;
        logic [8:0] sum;
        phase_next = phase_reg;
        wr_next = wr_reg;
        hi_next = hi_reg;
        lo_next = lo_reg;
        len_next = len_reg;
        done_next = done_reg;
        att_next = att_reg;
        dev_next = dev_reg;
        nres = '0;
        for (int i = 0; i < RES_MAX; i++)
        begin
            res[i] = '0;
        end
        do_try = 1'b0;
        do_fail = 1'b0;
        do_reply = 1'b0;
        try_byte = '0;
        try_ph = PH_IDLE;
        rp0 = '0;
        rp1 = '0;
        rst_st = ST_OK;
        big = (card_type_reg == 3'd5) || (card_type_reg == 3'd6);
        case (card_type_reg)
            3'd0: pmask = 8'h03;
            3'd1: pmask = 8'h07;
            3'd2, 3'd3, 3'd4: pmask = 8'h0F;
            3'd5, 3'd6: pmask = 8'h1F;
            default: pmask = 8'h00;
        endcase
        sum = {1'b0, addr_low} + {1'b0, length};
        top = 8'((9'd1 << (card_type_reg - 3'd1)) - 9'd1);
        d = 8'(done_reg + 8'd1);
        if (length == 8'd0 || length > max_len_reg)
            chk = ST_LEN;
        else if (card_type_reg == 3'd0)
            chk = (addr_high != 0 || addr_low > 8'd127 || length > 8'd128 || sum > 9'd128)
                  ? ST_LEN : ST_OK;
        else if (card_type_reg == 3'd1)
            chk = (addr_high != 0 || sum > 9'd256) ? ST_LEN : ST_OK;
        else if (card_type_reg == 3'd7)
            chk = ST_UNS;
        else
            chk = (addr_high > top || (addr_high == top && sum > 9'd256)) ? ST_LEN : ST_OK;

        if (fire)
        begin
            case (func)
                FN_HEADER:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        hi_next = addr_high;
                        lo_next = addr_low;
                        len_next = length;
                        if (chk == ST_LEN)
                        begin
                            do_reply = 1'b1; rp0 = 8'h67; rp1 = 8'h00; rst_st = ST_LEN;
                        end
                        else if (chk == ST_UNS || (ins != INS_READ && ins != INS_WRITE))
                        begin
                            do_reply = 1'b1; rp0 = 8'h6D; rp1 = 8'h00; rst_st = ST_UNS;
                        end
                        else
                        begin
                            wr_next = (ins == INS_WRITE);
                            done_next = '0;
                            dev_next = big ? DEV_BASE : (8'(addr_high << 1) | DEV_BASE);
                            att_next = '0;
                            do_try = 1'b1; try_byte = dev_next; try_ph = PH_DEV_ACK;
                        end
                    end
                end
                FN_DATA:
                begin
                    if (phase_reg == PH_WR_NEED)
                    begin
                        res[nres] = mk(K_WRITE, data_byte, 1'b0, 8'd0, 1'b0, ST_OK);
                        nres = nres + 3'd1;
                        phase_next = PH_WR_ACK;
                    end
                end
                FN_BUS:
                begin
                    case (phase_reg)
                        PH_DEV_ACK:
                        begin
                            if (bus_ack)
                            begin
                                res[nres] = mk(K_WRITE, big ? hi_reg : lo_reg, 1'b0, 8'd0,
                                               1'b0, ST_OK);
                                nres = nres + 3'd1;
                                phase_next = big ? PH_HI_FIRST : PH_LO_FIRST;
                            end
                            else
                            begin
                                if (att_reg != 8'hFF) att_next = att_reg + 8'd1;
                                do_try = 1'b1; try_byte = dev_reg; try_ph = PH_DEV_ACK;
                            end
                        end
                        PH_HI_FIRST, PH_HI_RETRY:
                        begin
                            if (bus_ack)
                            begin
                                res[nres] = mk(K_WRITE, lo_reg, 1'b0, 8'd0, 1'b0, ST_OK);
                                nres = nres + 3'd1;
                                phase_next = PH_LO_FIRST;
                            end
                            else
                            begin
                                if (phase_reg == PH_HI_RETRY && att_reg != 8'hFF)
                                    att_next = att_reg + 8'd1;
                                do_try = 1'b1; try_byte = hi_reg; try_ph = PH_HI_RETRY;
                            end
                        end
                        PH_LO_FIRST, PH_LO_RETRY:
                        begin
                            if (bus_ack)
                            begin
                                if (wr_reg)
                                begin
                                    res[nres] = mk(K_NEED, 8'd0, 1'b0, 8'd0, 1'b0, ST_OK);
                                    nres = nres + 3'd1;
                                    phase_next = PH_WR_NEED;
                                end
                                else
                                begin
                                    res[nres] = mk(K_START, 8'd0, 1'b0, 8'd0, 1'b0, ST_OK);
                                    nres = nres + 3'd1;
                                    res[nres] = mk(K_WRITE, dev_reg | 8'd1, 1'b0, 8'd0,
                                                   1'b0, ST_OK);
                                    nres = nres + 3'd1;
                                    phase_next = PH_RD_DEV_ACK;
                                end
                            end
                            else
                            begin
                                if (phase_reg == PH_LO_RETRY && att_reg != 8'hFF)
                                    att_next = att_reg + 8'd1;
                                do_try = 1'b1; try_byte = lo_reg; try_ph = PH_LO_RETRY;
                            end
                        end
                        PH_RD_DEV_ACK:
                        begin
                            if (!bus_ack)
                                do_fail = 1'b1;
                            else
                            begin
                                done_next = '0;
                                res[nres] = mk(K_READ, 8'd0, len_reg > 8'd1, 8'd0, 1'b0, ST_OK);
                                nres = nres + 3'd1;
                                phase_next = PH_RD_DATA;
                            end
                        end
                        PH_RD_DATA:
                        begin
                            res[nres] = mk(K_REPLY, 8'd0, 1'b0, bus_read_value, 1'b0, ST_OK);
                            nres = nres + 3'd1;
                            done_next = d;
                            if (d < len_reg)
                            begin
                                res[nres] = mk(K_READ, 8'd0,
                                               ({1'b0, d} + 9'd1) < {1'b0, len_reg},
                                               8'd0, 1'b0, ST_OK);
                                nres = nres + 3'd1;
                            end
                            else
                            begin
                                res[nres] = mk(K_STOP, 8'd0, 1'b0, 8'd0, 1'b0, ST_OK);
                                nres = nres + 3'd1;
                                do_reply = 1'b1; rp0 = 8'h90; rp1 = 8'h00; rst_st = ST_OK;
                            end
                        end
                        PH_WR_ACK:
                        begin
                            if (!bus_ack)
                                do_fail = 1'b1;
                            else
                            begin
                                lo_next = lo_reg + 8'd1;
                                if (lo_next == 8'd0) hi_next = hi_reg + 8'd1;
                                done_next = d;
                                if (d < len_reg && (lo_next & pmask) != 8'd0)
                                begin
                                    res[nres] = mk(K_NEED, 8'd0, 1'b0, 8'd0, 1'b0, ST_OK);
                                    nres = nres + 3'd1;
                                    phase_next = PH_WR_NEED;
                                end
                                else
                                begin
                                    res[nres] = mk(K_STOP, 8'd0, 1'b0, 8'd0, 1'b0, ST_OK);
                                    nres = nres + 3'd1;
                                    res[nres] = mk(K_WAIT, 8'd0, 1'b0, 8'd0, 1'b0, ST_OK);
                                    nres = nres + 3'd1;
                                    if (d < len_reg)
                                    begin
                                        dev_next = big ? DEV_BASE
                                                       : (8'(hi_next << 1) | DEV_BASE);
                                        att_next = '0;
                                        do_try = 1'b1; try_byte = dev_next;
                                        try_ph = PH_DEV_ACK;
                                    end
                                    else
                                    begin
                                        do_reply = 1'b1; rp0 = 8'h90; rp1 = 8'h00;
                                        rst_st = ST_OK;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase

            if (do_try)
            begin
                if (att_next >= retry_reg)
                    do_fail = 1'b1;
                else
                begin
                    res[nres] = mk(K_START, 8'd0, 1'b0, 8'd0, 1'b0, ST_OK);
                    nres = nres + 3'd1;
                    res[nres] = mk(K_WRITE, try_byte, 1'b0, 8'd0, 1'b0, ST_OK);
                    nres = nres + 3'd1;
                    phase_next = try_ph;
                end
            end
            if (do_fail)
            begin
                res[nres] = mk(K_STOP, 8'd0, 1'b0, 8'd0, 1'b0, ST_OK);
                nres = nres + 3'd1;
                if (wr_next)
                begin
                    res[nres] = mk(K_WAIT, 8'd0, 1'b0, 8'd0, 1'b0, ST_OK);
                    nres = nres + 3'd1;
                end
                do_reply = 1'b1; rp0 = 8'h65; rp1 = 8'h81; rst_st = ST_BUS;
            end
            if (do_reply)
            begin
                res[nres] = mk(K_REPLY, 8'd0, 1'b0, rp0, 1'b0, rst_st);
                nres = nres + 3'd1;
                res[nres] = mk(K_REPLY, 8'd0, 1'b0, rp1, 1'b1, rst_st);
                nres = nres + 3'd1;
                phase_next = PH_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            card_type_reg <= 3'd1;
            max_len_reg <= 8'd249;
            retry_reg <= 8'd80;
            phase_reg <= PH_IDLE;
            wr_reg <= 1'b0;
            hi_reg <= '0;
            lo_reg <= '0;
            len_reg <= '0;
            done_reg <= '0;
            att_reg <= '0;
            dev_reg <= DEV_BASE;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CARD_TYPE: card_type_reg <= cfg_data[2:0];
                    REG_MAX_LEN:   max_len_reg <= cfg_data;
                    REG_RETRY:     retry_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            phase_reg <= phase_next;
            wr_reg <= wr_next;
            hi_reg <= hi_next;
            lo_reg <= lo_next;
            len_reg <= len_next;
            done_reg <= done_next;
            att_reg <= att_next;
            dev_reg <= dev_next;
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(nres);
            if (pop) rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            cnt_reg <= cnt_reg + (PTR_W+1)'(nres) - (PTR_W+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < RES_MAX; i++)
        begin
            if (3'(i) < nres)
                fifo_mem[wr_ptr_reg + PTR_W'(i)] <= res[i];
        end
    end

endmodule

FILE: bench/eeprom_card_command_engine_test.sv
// Self-checking testbench for the EEPROM card command engine.
module eeprom_card_command_engine_test
    import eecce_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] FN_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_BEATS = 460;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] func = '0;
    logic [7:0] ins = '0;
    logic [7:0] addr_high = '0;
    logic [7:0] addr_low = '0;
    logic [7:0] length = '0;
    logic [7:0] data_byte = '0;
    logic       bus_ack = 1'b0;
    logic [7:0] bus_read_value = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [2:0] kind;
    logic [7:0] bus_byte;
    logic       send_ack;
    logic [7:0] reply;
    logic       last;
    logic [1:0] status;

    eeprom_card_command_engine DUT (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    // shadow of the engine
    logic [2:0] m_card;
    logic [7:0] m_max_len;
    logic [7:0] m_budget;
    logic [3:0] m_phase;
    logic       m_write;
    logic [7:0] m_high, m_low, m_total, m_done, m_tries, m_dev;

    result_t pending_ops[$];
    int errors = 0;
    int beats = 0;
    int cycles = 0;
    int burst_left = 0;

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic emit(input logic [2:0] k, input logic [7:0] bb, input logic a,
                        input logic [7:0] r, input logic l, input logic [1:0] s);
        result_t x;
        x = '{k, bb, a, r, l, s};
        pending_ops.push_back(x);
    endtask

    task automatic answer(input logic [7:0] b0, input logic [7:0] b1, input logic [1:0] s);
        emit(K_REPLY, 8'h00, 1'b0, b0, 1'b0, s);
        emit(K_REPLY, 8'h00, 1'b0, b1, 1'b1, s);
        m_phase = PH_IDLE;
    endtask

    task automatic abort_bus();
        emit(K_STOP, 8'h00, 1'b0, 8'h00, 1'b0, ST_OK);
        if (m_write) emit(K_WAIT, 8'h00, 1'b0, 8'h00, 1'b0, ST_OK);
        answer(8'h65, 8'h81, ST_BUS);
    endtask

    function automatic bit two_byte_addr();
        return m_card == 3'd5 || m_card == 3'd6;
    endfunction

    task automatic retry_byte(input logic [7:0] b, input logic [3:0] nxt);
        if (m_tries >= m_budget)
        begin
            abort_bus();
        end
        else
        begin
            emit(K_START, 8'h00, 1'b0, 8'h00, 1'b0, ST_OK);
            emit(K_WRITE, b, 1'b0, 8'h00, 1'b0, ST_OK);
            m_phase = nxt;
        end
    endtask

    task automatic bump_tries();
        if (m_tries != 8'hFF) m_tries++;
    endtask

    task automatic begin_addressing();
        m_dev = two_byte_addr() ? DEV_BASE : ((m_high << 1) | DEV_BASE);
        m_tries = '0;
        retry_byte(m_dev, PH_DEV_ACK);
    endtask

    function automatic logic [7:0] page_mask();
        case (m_card)
            3'd0: return 8'h03;
            3'd1: return 8'h07;
            3'd2, 3'd3, 3'd4: return 8'h0F;
            3'd5, 3'd6: return 8'h1F;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [1:0] header_check(input int hi, input int lo, input int len);
        int top;
        if (len == 0 || len > int'(m_max_len)) return ST_LEN;
        if (m_card == 3'd0)
            return (hi != 0 || lo > 127 || len > 128 || lo + len > 128) ? ST_LEN : ST_OK;
        if (m_card == 3'd1) return (hi != 0 || lo + len > 256) ? ST_LEN : ST_OK;
        if (m_card == 3'd7) return ST_UNS;
        top = (1 << (int'(m_card) - 1)) - 1;
        return (hi > top || (hi == top && lo + len > 256)) ? ST_LEN : ST_OK;
    endfunction

    task automatic predict_beat(input logic [1:0] f, input logic [7:0] i, input logic [7:0] ah,
                                input logic [7:0] al, input logic [7:0] len,
                                input logic [7:0] db, input logic ack, input logic [7:0] rv);
        logic [1:0] chk;
        if (f == FN_HEADER)
        begin
            if (m_phase != PH_IDLE) return;
            m_high = ah;
            m_low = al;
            m_total = len;
            chk = header_check(int'(ah), int'(al), int'(len));
            if (chk == ST_LEN) answer(8'h67, 8'h00, ST_LEN);
            else if (chk == ST_UNS || (i != INS_READ && i != INS_WRITE))
                answer(8'h6D, 8'h00, ST_UNS);
            else
            begin
                m_write = (i == INS_WRITE);
                m_done = '0;
                begin_addressing();
            end
            return;
        end
        if (f == FN_DATA)
        begin
            if (m_phase != PH_WR_NEED) return;
            emit(K_WRITE, db, 1'b0, 8'h00, 1'b0, ST_OK);
            m_phase = PH_WR_ACK;
            return;
        end
        if (f != FN_BUS) return;
        case (m_phase)
            PH_DEV_ACK:
            begin
                if (ack)
                begin
                    if (two_byte_addr())
                    begin
                        emit(K_WRITE, m_high, 1'b0, 8'h00, 1'b0, ST_OK);
                        m_phase = PH_HI_FIRST;
                    end
                    else
                    begin
                        emit(K_WRITE, m_low, 1'b0, 8'h00, 1'b0, ST_OK);
                        m_phase = PH_LO_FIRST;
                    end
                end
                else
                begin
                    bump_tries();
                    retry_byte(m_dev, PH_DEV_ACK);
                end
            end
            PH_HI_FIRST, PH_HI_RETRY:
            begin
                if (ack)
                begin
                    emit(K_WRITE, m_low, 1'b0, 8'h00, 1'b0, ST_OK);
                    m_phase = PH_LO_FIRST;
                end
                else
                begin
                    if (m_phase == PH_HI_RETRY) bump_tries();
                    retry_byte(m_high, PH_HI_RETRY);
                end
            end
            PH_LO_FIRST, PH_LO_RETRY:
            begin
                if (ack)
                begin
                    if (m_write)
                    begin
                        emit(K_NEED, 8'h00, 1'b0, 8'h00, 1'b0, ST_OK);
                        m_phase = PH_WR_NEED;
                    end
                    else
                    begin
                        emit(K_START, 8'h00, 1'b0, 8'h00, 1'b0, ST_OK);
                        emit(K_WRITE, m_dev | 8'h01, 1'b0, 8'h00, 1'b0, ST_OK);
                        m_phase = PH_RD_DEV_ACK;
                    end
                end
                else
                begin
                    if (m_phase == PH_LO_RETRY) bump_tries();
                    retry_byte(m_low, PH_LO_RETRY);
                end
            end
            PH_RD_DEV_ACK:
            begin
                if (!ack) abort_bus();
                else
                begin
                    m_done = '0;
                    emit(K_READ, 8'h00, m_total > 8'd1, 8'h00, 1'b0, ST_OK);
                    m_phase = PH_RD_DATA;
                end
            end
            PH_RD_DATA:
            begin
                emit(K_REPLY, 8'h00, 1'b0, rv, 1'b0, ST_OK);
                m_done++;
                if (m_done < m_total)
                    emit(K_READ, 8'h00, (int'(m_done) + 1 < int'(m_total)), 8'h00, 1'b0,
                         ST_OK);
                else
                begin
                    emit(K_STOP, 8'h00, 1'b0, 8'h00, 1'b0, ST_OK);
                    answer(8'h90, 8'h00, ST_OK);
                end
            end
            PH_WR_ACK:
            begin
                if (!ack) abort_bus();
                else
                begin
                    m_low++;
                    if (m_low == 8'd0) m_high++;
                    m_done++;
                    if (m_done < m_total && (m_low & page_mask()) != 8'd0)
                    begin
                        emit(K_NEED, 8'h00, 1'b0, 8'h00, 1'b0, ST_OK);
                        m_phase = PH_WR_NEED;
                    end
                    else
                    begin
                        emit(K_STOP, 8'h00, 1'b0, 8'h00, 1'b0, ST_OK);
                        emit(K_WAIT, 8'h00, 1'b0, 8'h00, 1'b0, ST_OK);
                        if (m_done < m_total) begin_addressing();
                        else answer(8'h90, 8'h00, ST_OK);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // called at a rising edge; returns at the edge that accepted the beat
    task automatic send_beat(input logic [1:0] f, input logic [7:0] i, input logic [7:0] ah,
                             input logic [7:0] al, input logic [7:0] len,
                             input logic [7:0] db, input logic ack, input logic [7:0] rv);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 5);
            burst_left = $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        func <= f;
        ins <= i;
        addr_high <= ah;
        addr_low <= al;
        length <= len;
        data_byte <= db;
        bus_ack <= ack;
        bus_read_value <= rv;
        do @(posedge clk); while (!in_ready);
        predict_beat(f, i, ah, al, len, db, ack, rv);
        beats++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_ops.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [7:0] v);
        in_valid <= 1'b0;
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_CARD_TYPE: m_card = v[2:0];
            REG_MAX_LEN:   m_max_len = v;
            REG_RETRY:     m_budget = v;
            default: ;
        endcase
    endtask

    task automatic send_noise();
        logic [1:0] f;
        case ($urandom_range(0, 2))
            0: f = FN_NONE;
            1: f = FN_HEADER;
            default: f = (m_phase == PH_WR_NEED) ? FN_BUS : FN_DATA;
        endcase
        if (m_phase == PH_IDLE && f == FN_HEADER) f = FN_NONE;
        if (m_phase == PH_IDLE && f == FN_DATA) f = FN_BUS;
        send_beat(f, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  1'($urandom), 8'($urandom));
    endtask

    // header, then data bytes, bus answers as a device would and some noise beats until the reply is done
    task automatic run_command(input logic [7:0] i, input logic [7:0] ah, input logic [7:0] al,
                               input logic [7:0] len, input int nack_pct);
        send_beat(FN_HEADER, i, ah, al, len, 8'($urandom), 1'($urandom), 8'($urandom));
        while (m_phase != PH_IDLE)
        begin
            if ($urandom_range(0, 99) < 4) send_noise();
            else if (m_phase == PH_WR_NEED)
                send_beat(FN_DATA, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom), 1'($urandom), 8'($urandom));
            else
                send_beat(FN_BUS, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom), $urandom_range(0, 99) >= nack_pct, 8'($urandom));
        end
    endtask

    task automatic random_command(input int nack_pct);
        logic [7:0] i, ah, al, len;
        int top, span;
        i = ($urandom_range(0, 9) < 5) ? INS_READ : INS_WRITE;
        if ($urandom_range(0, 19) == 0) i = 8'($urandom);
        len = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(1, 40))
                                           : 8'($urandom_range(1, 8));
        if (m_card <= 3'd1)
        begin
            ah = 8'd0;
            span = (m_card == 3'd0) ? 128 : 256;
            if (int'(len) > span) len = 8'(span);
            al = 8'($urandom_range(0, span - int'(len)));
        end
        else
        begin
            top = (m_card == 3'd7) ? 255 : (1 << (int'(m_card) - 1)) - 1;
            ah = 8'($urandom_range(0, top));
            al = 8'($urandom);
            if (int'(ah) == top && int'(al) + int'(len) > 256) al = 8'(256 - int'(len));
        end
        if ($urandom_range(0, 9) == 0)
        begin
            ah = 8'($urandom);
            al = 8'($urandom);
            len = 8'($urandom);
        end
        run_command(i, ah, al, len, nack_pct);
    endtask

    task automatic test_header_checks();
        set_reg(REG_CARD_TYPE, 8'd1);
        set_reg(REG_MAX_LEN, 8'd255);
        run_command(INS_READ, 8'd0, 8'd0, 8'd0, 0);
        run_command(8'hFF, 8'd0, 8'd0, 8'd4, 0);
        run_command(8'h00, 8'd0, 8'd0, 8'd4, 0);
        run_command(INS_WRITE, 8'd1, 8'd0, 8'd4, 0);
        run_command(INS_READ, 8'd0, 8'd255, 8'd2, 0);
        drain();
        set_reg(REG_MAX_LEN, 8'd1);
        run_command(INS_READ, 8'd0, 8'd0, 8'd2, 0);
        run_command(INS_READ, 8'd0, 8'd255, 8'd1, 0);
        drain();
        set_reg(REG_MAX_LEN, 8'd255);
        set_reg(REG_CARD_TYPE, 8'd0);
        run_command(INS_READ, 8'd0, 8'd128, 8'd1, 0);
        run_command(INS_READ, 8'd0, 8'd127, 8'd2, 0);
        drain();
        set_reg(REG_CARD_TYPE, 8'd7);
        run_command(INS_READ, 8'd0, 8'd0, 8'd1, 0);
        drain();
        set_reg(REG_CARD_TYPE, 8'd6);
        run_command(INS_WRITE, 8'd32, 8'd0, 8'd1, 0);
        run_command(INS_READ, 8'd31, 8'd255, 8'd2, 0);
        drain();
    endtask

    task automatic test_read_write();
        set_reg(REG_CARD_TYPE, 8'd6);
        run_command(INS_READ, 8'd31, 8'd254, 8'd2, 0);
        run_command(INS_WRITE, 8'd3, 8'd30, 8'd4, 0);
        drain();
        set_reg(REG_CARD_TYPE, 8'd0);
        run_command(INS_WRITE, 8'd0, 8'd2, 8'd6, 0);
        run_command(INS_READ, 8'd0, 8'd127, 8'd1, 0);
        drain();
        set_reg(REG_CARD_TYPE, 8'd2);
        run_command(INS_WRITE, 8'd1, 8'd255, 8'd2, 0);
        drain();
    endtask

    task automatic test_retries();
        set_reg(REG_CARD_TYPE, 8'd5);
        set_reg(REG_RETRY, 8'd2);
        run_command(INS_READ, 8'd4, 8'd16, 8'd3, 60);
        run_command(INS_WRITE, 8'd4, 8'd16, 8'd3, 60);
        drain();
        set_reg(REG_RETRY, 8'd0);
        run_command(INS_WRITE, 8'd0, 8'd0, 8'd1, 0);
        drain();
        set_reg(REG_RETRY, 8'd255);
        run_command(INS_READ, 8'd0, 8'd0, 8'd1, 50);
        drain();
    endtask

    task automatic test_random();
        int stop_at;
        while (beats < RANDOM_BEATS)
        begin
            set_reg(REG_CARD_TYPE, 8'($urandom_range(0, 7)));
            set_reg(REG_MAX_LEN, ($urandom_range(0, 4) == 0) ? 8'd255
                                                            : 8'($urandom_range(1, 255)));
            set_reg(REG_RETRY, ($urandom_range(0, 4) == 0) ? 8'd1
                                                          : 8'($urandom_range(1, 255)));
            stop_at = beats + 60;
            while (beats < stop_at) random_command($urandom_range(0, 1) ? 5 : 25);
            drain();
        end
    endtask

    // receiver stall pattern
    int stall_mode = 0;
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= int'($urandom_range(0, 3));
            stall_left <= int'($urandom_range(5, 60));
        end
        else stall_left <= stall_left - 1;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (stall_left % 7) != 0;
        endcase
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_ops.size() == 0)
            begin
                report($sformatf("unexpected result kind %0d", kind));
            end
            else
            begin
                want = pending_ops.pop_front();
                if (kind !== want.kind)
                    report($sformatf("kind %0d, want %0d", kind, want.kind));
                if (bus_byte !== want.bus_byte)
                    report($sformatf("bus_byte %h, want %h", bus_byte, want.bus_byte));
                if (send_ack !== want.send_ack)
                    report($sformatf("send_ack %b, want %b", send_ack, want.send_ack));
                if (reply !== want.reply)
                    report($sformatf("reply %h, want %h", reply, want.reply));
                if (last !== want.last)
                    report($sformatf("last %b, want %b", last, want.last));
                if (status !== want.status)
                    report($sformatf("status %0d, want %0d", status, want.status));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        m_card = 3'd1;
        m_max_len = 8'd249;
        m_budget = 8'd80;
        m_phase = PH_IDLE;
        m_write = 1'b0;
        m_high = '0;
        m_low = '0;
        m_total = '0;
        m_done = '0;
        m_tries = '0;
        m_dev = DEV_BASE;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_command(INS_READ, 8'd0, 8'd10, 8'd2, 0);
        drain();
        test_header_checks();
        test_read_write();
        test_retries();
        test_random();
        drain();
        repeat (20) @(posedge clk);
        if (errors == 0 && pending_ops.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: eeprom_card_command_engine.f
hdl/eecce_pkg.sv
hdl/eeprom_card_command_engine.sv
bench/eeprom_card_command_engine_test.sv
